/* hw/rtl/rdq_pkg.sv */
// Shared types, constants and slot arithmetic for the record deque.
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REC_W    = 64;
  localparam int OCC_W    = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } rdq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } rdq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } rdq_state_e;

  typedef struct packed {
    logic [15:0] name_handle;
    logic [15:0] price;
    logic [15:0] size;
    logic [15:0] id;
  } rdq_rec_t;

  typedef struct packed {
    rdq_status_e      status;
    rdq_rec_t         rec;
    logic [OCC_W-1:0] occupancy;
  } rdq_res_t;

  // Slot of the record k places behind the front, wrapped into the store.
  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] front,
                                               logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(front) + (CNT_W + 1)'(k);
    if (s >= (CNT_W + 1)'(CAPACITY)) begin
      s = s - (CNT_W + 1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
  endfunction

endpackage

/* hw/rtl/record_deque_with_keyed_delete_top.sv */
// Top level of the record deque: input packing, sequencer and result register.
`timescale 1ns / 1ps

// Bounded deque of up to 16 records (id, size, price, name handle) with
// push/pop at either end and removal of the first record from the front
// whose id matches. Every accepted transfer yields exactly one result
// transfer carrying a status, the removed record (zeros unless a record
// was removed) and the occupancy after the operation. Records live in a
// simple dual-port RAM with registered read data; the store needs no
// clearing after reset, since only occupied slots are read. One operation
// is in flight at a time. A keyed removal uses the single RAM read port to
// first walk the records from the front and then move each record behind
// the match down by one slot. The result register lets the next input
// transfer be accepted while a finished result still waits on out_stall_i.
module record_deque_with_keyed_delete_top
  import rdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] record_id_i,
  input  logic [15:0] record_size_i,
  input  logic [15:0] record_price_i,
  input  logic [15:0] name_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_size_o,
  output logic [15:0] out_price_o,
  output logic [15:0] out_name_handle_o,
  output logic [4:0]  occupancy_o
);

  rdq_rec_t in_rec;
  logic     res_valid;
  logic     res_ready;
  rdq_res_t res;
  logic     out_valid_q;
  rdq_res_t out_q;

  // Pack the input fields into the stored record layout.
  assign in_rec.id          = record_id_i;
  assign in_rec.size        = record_size_i;
  assign in_rec.price       = record_price_i;
  assign in_rec.name_handle = name_handle_i;

  rdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .rec_i      (in_rec),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The result register takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload while a stalled transfer waits.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign out_id_o          = out_q.rec.id;
  assign out_size_o        = out_q.rec.size;
  assign out_price_o       = out_q.rec.price;
  assign out_name_handle_o = out_q.rec.name_handle;
  assign occupancy_o       = out_q.occupancy;

endmodule

/* hw/rtl/rdq_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module rdq_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rdq_ctrl.sv */
// Sequencer for the deque: front and count registers, scan and compaction.
`timescale 1ns / 1ps

module rdq_ctrl
  import rdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  rdq_rec_t    rec_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output rdq_res_t    res_o
);

  rdq_state_e       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [15:0]      key_q, key_d;
  rdq_status_e      status_q, status_d;
  rdq_rec_t         got_q, got_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rdq_rec_t         ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  rdq_rec_t         ram_rdata;

  logic             full;
  logic [CNT_W-1:0] k_next;
  logic [CNT_W-1:0] k_next2;

  rdq_ram #(
    .DATA_W(REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign k_next  = k_q + CNT_W'(1);
  assign k_next2 = k_q + CNT_W'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    key_q    <= key_d;
    status_q <= status_d;
    got_q    <= got_d;
  end

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    k_d       = k_q;
    key_d     = key_q;
    status_d  = status_q;
    got_d     = got_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          got_d    = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (opcode_i) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = rec_i;
                if (opcode_i == OP_PUSH_FRONT) begin
                  ram_waddr = slot_dec(front_q);
                  front_d   = ram_waddr;
                end else begin
                  ram_waddr = slot_of(front_q, count_q);
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (opcode_i == OP_POP_FRONT) begin
                ram_raddr = front_q;
                front_d   = slot_inc(front_q);
                count_d   = count_q - CNT_W'(1);
                state_d   = S_POP;
              end else if (opcode_i == OP_POP_BACK) begin
                ram_raddr = slot_of(front_q, count_q - CNT_W'(1));
                count_d   = count_q - CNT_W'(1);
                state_d   = S_POP;
              end else begin
                // start the scan at the front; one read issued per cycle
                ram_raddr = front_q;
                k_d       = '0;
                key_d     = rec_i.id;
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        got_d   = ram_rdata;
        state_d = S_DONE;
      end

      S_SCAN: begin
        // read data belongs to entry k; prefetch entry k+1
        ram_raddr = slot_of(front_q, k_next);
        if (ram_rdata.id == key_q) begin
          got_d    = ram_rdata;
          status_d = ST_OK;
          if (k_next >= count_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (k_next >= count_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          k_d = k_next;
        end
      end

      S_SHIFT: begin
        // move entry k+1 down into slot k, fetch entry k+2
        ram_we    = 1'b1;
        ram_waddr = slot_of(front_q, k_q);
        ram_wdata = ram_rdata;
        ram_raddr = slot_of(front_q, k_next2);
        if (k_next2 >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          k_d = k_next;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.status     = status_q;
  assign res_o.rec        = got_q;
  assign res_o.occupancy  = OCC_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("record count exceeds capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !full &&
    (opcode_i == OP_PUSH_FRONT || opcode_i == OP_PUSH_BACK)
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted push did not add a record");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_q == ST_FULL |-> full && got_q == '0)
    else $error("full status without a full store");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_q == ST_EMPTY |-> count_q == '0 && got_q == '0)
    else $error("empty status with records held");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the record deque with keyed delete.
`timescale 1ns / 1ps

module testbench;
  import rdq_pkg::*;

  // Opcodes beyond remove; the block treats them as no-ops.
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam int IDLE_PCT     = 16;      // chance per cycle that a side idles
  localparam int SETTLE_CYC   = 24;      // idle wait after a drain, to cover the longest keyed removal
  localparam int DRAIN_LIMIT  = 5000;    // cycles to wait for the last results
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [15:0] rec_id;
  logic [15:0] rec_size;
  logic [15:0] rec_price;
  logic [15:0] rec_name;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [15:0] out_size;
  logic [15:0] out_price;
  logic [15:0] out_name;
  logic [4:0]  occupancy;

  // Shadow copy of the deque, kept in step with accepted transfers.
  rdq_rec_t shadow_store [CAPACITY];
  int       shadow_count;
  int       shadow_front;
  int       peak_count;

  // Results the block still owes, oldest first.
  rdq_res_t pending_results[$];

  int  error_count;
  int  items_sent;
  int  status_seen [4];
  bit  calm;          // suppress idling on both sides for a stretch

  record_deque_with_keyed_delete_top i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .record_id_i       (rec_id),
    .record_size_i     (rec_size),
    .record_price_i    (rec_price),
    .name_handle_i     (rec_name),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .out_id_o          (out_id),
    .out_size_o        (out_size),
    .out_price_o       (out_price),
    .out_name_handle_o (out_name),
    .occupancy_o       (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Count a failure; report only the first few in detail.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Apply one accepted operation to the shadow deque and queue the result it owes.
  task automatic apply_operation(input logic [2:0] op, input rdq_rec_t rec);
    rdq_res_t res;
    int       k;
    int       hit;
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
            shadow_store[shadow_front] = rec;
          end else begin
            shadow_store[(shadow_front + shadow_count) % CAPACITY] = rec;
          end
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.rec      = shadow_store[shadow_front];
          shadow_front = (shadow_front + 1) % CAPACITY;
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.rec = shadow_store[(shadow_front + shadow_count - 1) % CAPACITY];
          shadow_count--;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Find the first match from the front, then close the gap behind it.
          hit = -1;
          for (k = 0; k < shadow_count && hit < 0; k++) begin
            if (shadow_store[(shadow_front + k) % CAPACITY].id == rec.id) hit = k;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.rec = shadow_store[(shadow_front + hit) % CAPACITY];
            for (k = hit; k + 1 < shadow_count; k++) begin
              shadow_store[(shadow_front + k) % CAPACITY] =
                shadow_store[(shadow_front + k + 1) % CAPACITY];
            end
            shadow_count--;
          end
        end
      end
      default: ;  // unused opcodes leave the store alone
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    res.occupancy = shadow_count[4:0];
    pending_results.push_back(res);
  endtask

  // Offer one transfer, idling first at random, and hold it until accepted.
  // Valid is only lowered when idling, so back-to-back transfers keep it high.
  task automatic send_op(input logic [2:0] op, input logic [15:0] id,
                         input logic [15:0] size, input logic [15:0] price,
                         input logic [15:0] name);
    rdq_rec_t rec;
    rec = '{name_handle: name, price: price, size: size, id: id};
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    rec_id    <= id;
    rec_size  <= size;
    rec_price <= price;
    rec_name  <= name;
    // Stall seen here is the value settled before this edge.
    do @(posedge clk); while (in_stall);
    apply_operation(op, rec);
    items_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(input int push_pct, input int remove_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    if (r < 3 + push_pct) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < 3 + push_pct + remove_pct) return OP_REMOVE;
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Keys come mostly from a small pool so removals hit; some span all 16 bits.
  function automatic logic [15:0] pick_key(input bit from_store);
    if (from_store && shadow_count > 0) begin
      return shadow_store[(shadow_front + $urandom_range(shadow_count - 1)) % CAPACITY].id;
    end
    if ($urandom_range(99) < 75) return 16'($urandom_range(11));
    return 16'($urandom());
  endfunction

  task automatic send_random(input int push_pct, input int remove_pct, input int hit_pct);
    logic [2:0] op;
    op = pick_op(push_pct, remove_pct);
    send_op(op, pick_key(op == OP_REMOVE && $urandom_range(99) < hit_pct),
            16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // Empty-store cases: pops and removal report empty, a no-op reports ok.
  task automatic test_empty_store();
    send_op(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_POP_FRONT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(OP_POP_BACK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // Fill to capacity from both ends with extreme records, then overflow.
  task automatic test_fill_and_overflow();
    int k;
    send_op(OP_PUSH_FRONT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_PUSH_BACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (k = 0; k < CAPACITY - 2; k++) begin
      send_op(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, 16'(k % 5),
              16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    send_op(OP_PUSH_FRONT, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_op(OP_PUSH_BACK, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_op(OP_FIRST_UNUSED, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
  endtask

  // Keyed removal: a missing id, then an id held several times (first from
  // the front goes), then a pop from each end.
  task automatic test_keyed_remove();
    send_op(OP_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_REMOVE, 16'h0003, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_POP_FRONT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_POP_BACK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Random mix; alternate between filling and draining bias so the store
  // swings between empty and full many times.
  task automatic test_random_mix(input int count);
    int k;
    bit filling;
    filling = 1'b1;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(39) == 0) filling = !filling;
      if (filling) send_random(60, 17, 60);
      else         send_random(30, 32, 60);
    end
  endtask

  // Back-to-back stream with no idling on either side.
  task automatic test_calm_stream(input int count);
    int k;
    calm = 1'b1;
    for (k = 0; k < count; k++) send_random(48, 25, 60);
    calm = 1'b0;
  endtask

  // Keep the store well filled and mostly remove ids that are held,
  // so the scan and compaction run over long spans.
  task automatic test_remove_heavy(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (shadow_count < CAPACITY / 2) send_random(85, 10, 85);
      else                             send_random(42, 50, 85);
    end
  endtask

  // Check each result transfer against the oldest expectation, then pick
  // the stall for the next cycle.
  always @(posedge clk) begin : check_results
    rdq_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing owed: status %0d id %h occ %0d",
                               status, out_id, occupancy));
        end else begin
          want = pending_results.pop_front();
          status_seen[status]++;
          if (status !== want.status)
            flag_error($sformatf("status exp %0d got %0d", want.status, status));
          if (out_id !== want.rec.id)
            flag_error($sformatf("id exp %h got %h", want.rec.id, out_id));
          if (out_size !== want.rec.size)
            flag_error($sformatf("size exp %h got %h", want.rec.size, out_size));
          if (out_price !== want.rec.price)
            flag_error($sformatf("price exp %h got %h", want.rec.price, out_price));
          if (out_name !== want.rec.name_handle)
            flag_error($sformatf("name exp %h got %h", want.rec.name_handle, out_name));
          if (occupancy !== want.occupancy)
            flag_error($sformatf("occupancy exp %0d got %0d", want.occupancy, occupancy));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : run_tests
    int waited;
    in_valid     = 1'b0;
    opcode       = '0;
    rec_id       = '0;
    rec_size     = '0;
    rec_price    = '0;
    rec_name     = '0;
    rst_n        = 1'b0;
    shadow_count = 0;
    shadow_front = 0;
    peak_count   = 0;
    error_count  = 0;
    items_sent   = 0;
    calm         = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_fill_and_overflow();
    test_keyed_remove();
    // Hold off until the block has returned everything.
    wait_for_drain();
    test_random_mix(1100);
    wait_for_drain();
    test_calm_stream(400);
    test_remove_heavy(500);

    // Wait out the last results, bounded, then let the block settle.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Covered %0d transfers: ok %0d, empty %0d, not found %0d, full %0d.",
             items_sent, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    $display("Peak occupancy %0d of %0d; %0d mismatches.", peak_count, CAPACITY,
             error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* record_deque_with_keyed_delete_top.f */
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_ram.sv
hw/rtl/rdq_ctrl.sv
hw/rtl/record_deque_with_keyed_delete_top.sv
tb/testbench.sv
